// ===== hw/rtl/utf8_stream_decoder_unit_assert.svh =====
// Assertion macros used by the decoder output stage (utf8sd_back).
`ifndef UTF8_STREAM_DECODER_UNIT_ASSERT_SVH
`define UTF8_STREAM_DECODER_UNIT_ASSERT_SVH

// condition must hold while the block is out of reset
`define U8SD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define U8SD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define U8SD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/utf8sd_pkg.sv =====
// Types and constants shared by the UTF-8 stream decoder modules.
package utf8sd_pkg;

    localparam int CP_W = 31;

    localparam logic [CP_W-1:0] CODE_LIMIT      = 31'h0011_0000;
    localparam logic [CP_W-1:0] REPL_CHAR_RESET = 31'h0000_FFFD;

    localparam logic CMD_DECODE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    localparam logic REG_IDX_ENABLE = 1'b0;
    localparam logic REG_IDX_CHAR   = 1'b1;

    typedef struct packed {
        logic            repl_enable;
        logic [CP_W-1:0] repl_char;
    } cfg_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            is_repl;
    } result_t;

    typedef struct packed {
        result_t first;
        logic    has_second;
        result_t second;
    } q_entry_t;

endpackage

// ===== hw/rtl/utf8sd_front.sv =====
// Front end: accepts bytes and flushes, tracks the pending sequence, builds result entries.
module utf8sd_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_command,
    input  logic [7:0]            s_byte_value,
    input  utf8sd_pkg::cfg_t      cfg,
    input  logic                  q_full,
    output logic                  q_push,
    output utf8sd_pkg::q_entry_t  q_entry
);

    logic [2:0]                  pend_reg, pend_next;
    logic [utf8sd_pkg::CP_W-1:0] part_reg, part_next;
    logic [4:0]                  minb_reg, minb_next;

    logic                        accept;
    logic                        lead;
    logic                        err_a;
    logic                        res_b;
    logic                        emit_a;
    logic                        emit_b;
    logic                        seq_ok;
    logic [utf8sd_pkg::CP_W-1:0] shifted;
    utf8sd_pkg::result_t         res_a_val;
    utf8sd_pkg::result_t         res_b_val;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign shifted = {part_reg[utf8sd_pkg::CP_W-7:0], s_byte_value[5:0]};
    assign seq_ok  = ((shifted >> minb_reg) != '0) && (shifted < utf8sd_pkg::CODE_LIMIT);

    always_comb begin
        pend_next = pend_reg;
        part_next = part_reg;
        minb_next = minb_reg;
        lead      = 1'b0;
        err_a     = 1'b0;
        res_b     = 1'b0;
        res_b_val = '{code_point: cfg.repl_char, is_repl: 1'b1};
        res_a_val = '{code_point: cfg.repl_char, is_repl: 1'b1};

        if (s_command == utf8sd_pkg::CMD_FLUSH) begin
            err_a     = (pend_reg != 3'd0);
            pend_next = '0;
            part_next = '0;
            minb_next = '0;
        end else begin
            lead = 1'b1;
            if (pend_reg != 3'd0) begin
                if (s_byte_value[7:6] == 2'b10) begin
                    lead      = 1'b0;
                    part_next = shifted;
                    pend_next = pend_reg - 3'd1;
                    if (pend_reg == 3'd1) begin
                        res_b = 1'b1;
                        if (seq_ok) begin
                            res_b_val = '{code_point: shifted, is_repl: 1'b0};
                        end
                        part_next = '0;
                        minb_next = '0;
                    end
                end else begin
                    err_a     = 1'b1;
                    pend_next = '0;
                    part_next = '0;
                    minb_next = '0;
                end
            end
            if (lead) begin
                unique casez (s_byte_value)
                    8'b0???????: begin
                        res_b     = 1'b1;
                        res_b_val = '{code_point: {23'd0, s_byte_value}, is_repl: 1'b0};
                    end
                    8'b10??????: begin
                        res_b = 1'b1;
                    end
                    8'b110?????: begin
                        pend_next = 3'd1;
                        part_next = {26'd0, s_byte_value[4:0]};
                        minb_next = 5'd7;
                    end
                    8'b1110????: begin
                        pend_next = 3'd2;
                        part_next = {27'd0, s_byte_value[3:0]};
                        minb_next = 5'd11;
                    end
                    8'b11110???: begin
                        pend_next = 3'd3;
                        part_next = {28'd0, s_byte_value[2:0]};
                        minb_next = 5'd16;
                    end
                    8'b111110??: begin
                        pend_next = 3'd4;
                        part_next = {29'd0, s_byte_value[1:0]};
                        minb_next = 5'd21;
                    end
                    8'b1111110?: begin
                        pend_next = 3'd5;
                        part_next = {30'd0, s_byte_value[0]};
                        minb_next = 5'd26;
                    end
                    default: begin
                        res_b = 1'b1;
                    end
                endcase
            end
        end
    end

    assign emit_a = err_a && cfg.repl_enable;
    assign emit_b = res_b && (!res_b_val.is_repl || cfg.repl_enable);

    always_comb begin
        q_entry.first      = emit_a ? res_a_val : res_b_val;
        q_entry.has_second = emit_a && emit_b;
        q_entry.second     = res_b_val;
    end

    assign q_push = accept && (emit_a || emit_b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
            part_reg <= '0;
            minb_reg <= '0;
        end else if (accept) begin
            pend_reg <= pend_next;
            part_reg <= part_next;
            minb_reg <= minb_next;
        end
    end

endmodule

// ===== hw/rtl/utf8sd_queue.sv =====
// Result entry queue between the front end and the output stage.
module utf8sd_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  utf8sd_pkg::q_entry_t push_entry,
    output logic                 full,
    input  logic                 pop,
    output logic                 q_valid,
    output utf8sd_pkg::q_entry_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    utf8sd_pkg::q_entry_t slot_reg [DEPTH];
    logic [PW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]        cnt_reg, cnt_next;

    assign full    = (cnt_reg == FULL_CNT);
    assign q_valid = (cnt_reg != '0);
    assign head    = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hw/rtl/utf8sd_back.sv =====
// Output stage: unpacks queue entries into one result beat per cycle while m_ready accepts them.
module utf8sd_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    input  utf8sd_pkg::q_entry_t        head,
    output logic                        pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [utf8sd_pkg::CP_W-1:0] m_code_point,
    output logic                        m_is_replacement,
    output logic                        m_last
);

    `include "utf8_stream_decoder_unit_assert.svh"

    logic                 m_valid_reg;
    logic                 m_last_reg;
    utf8sd_pkg::result_t  out_reg;
    logic                 sec_valid_reg;
    utf8sd_pkg::result_t  sec_reg;
    logic                 out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign pop      = out_free && !sec_valid_reg && q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            sec_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (sec_valid_reg) begin
                m_valid_reg   <= 1'b1;
                sec_valid_reg <= 1'b0;
            end else begin
                m_valid_reg   <= q_valid;
                sec_valid_reg <= q_valid && head.has_second;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (sec_valid_reg) begin
                out_reg    <= sec_reg;
                m_last_reg <= 1'b1;
            end else begin
                out_reg    <= head.first;
                m_last_reg <= !head.has_second;
                sec_reg    <= head.second;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_code_point     = out_reg.code_point;
    assign m_is_replacement = out_reg.is_repl;
    assign m_last           = m_last_reg;

    `U8SD_ASSERT_IMPLIES(a_second_has_first, sec_valid_reg, m_valid_reg,
        "second held without first")
    `U8SD_ASSERT_IMPLIES(a_not_last_pairs, m_valid_reg && !m_last_reg, sec_valid_reg,
        "orphan beat")
    `U8SD_ASSERT_NEXT(a_second_is_last, m_valid_reg && m_ready && sec_valid_reg,
        m_valid_reg && m_last_reg, "second beat lost")

endmodule

// ===== hw/rtl/utf8_stream_decoder_unit.sv =====
// Top level of the streaming UTF-8 decoder with APB register port.
// Usage:
//   Input channel s_*: one beat carries a byte (s_command = 0) or a flush (s_command = 1).
//   Result channel m_*: one beat per decoded code point or replacement character;
//   m_last marks the final result of an input beat, which gives zero, one or two.
//   Throughput: one input beat per cycle while the queue is not full; the output stage sends
//   one result per cycle while m_ready is high, so an input beat that yields two results takes two output beats.
//   Path: the entry of an accepted input beat is written into the result queue at the
//   accepting edge and then loaded into the output register, where m_valid rises;
//   a second result follows in the cycle after the first is taken.
//   The result queue of QUEUE_DEPTH entries lets the front end keep taking bytes
//   while the receiver stalls; s_ready drops only when the queue is full.
//   Registers (APB, write at psel & penable & pwrite): 0x0 replacement enable,
//   0x4 replacement character; reset values 1 and 0xFFFD.
//   Reset (aresetn low, synchronous) clears any pending sequence, the queue
//   and the output valid flags.
module utf8_stream_decoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_command,
    input  logic [7:0]                  s_byte_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [utf8sd_pkg::CP_W-1:0] m_code_point,
    output logic                        m_is_replacement,
    output logic                        m_last
);

    utf8sd_pkg::cfg_t     cfg_reg;
    logic                 cfg_wr;
    logic                 q_push;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_valid;
    utf8sd_pkg::q_entry_t q_in;
    utf8sd_pkg::q_entry_t q_head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.repl_enable <= 1'b1;
            cfg_reg.repl_char   <= utf8sd_pkg::REPL_CHAR_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == utf8sd_pkg::REG_IDX_ENABLE) begin
                cfg_reg.repl_enable <= pwdata[0];
            end else begin
                cfg_reg.repl_char <= pwdata[utf8sd_pkg::CP_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == utf8sd_pkg::REG_IDX_CHAR) begin
            prdata = {1'b0, cfg_reg.repl_char};
        end else begin
            prdata = {31'd0, cfg_reg.repl_enable};
        end
    end

    utf8sd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_byte_value (s_byte_value),
        .cfg          (cfg_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_entry      (q_in)
    );

    utf8sd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .q_valid    (q_valid),
        .head       (q_head)
    );

    utf8sd_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .head             (q_head),
        .pop              (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_code_point     (m_code_point),
        .m_is_replacement (m_is_replacement),
        .m_last           (m_last)
    );

endmodule
